// ===== src/vsk_pkg.sv =====
package vsk_pkg;

  typedef enum logic [2:0] {
    REG_BYPASS    = 3'd0,
    REG_AMPLITUDE = 3'd1,
    REG_SLEW      = 3'd2,
    REG_BRAKE     = 3'd3,
    REG_ZERO_BAND = 3'd4,
    REG_TRACK_SUM = 3'd5
  } cfg_reg_e;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 15;

  localparam logic        BypassRst    = 1'b0;
  localparam logic [14:0] AmplitudeRst = 15'd14336;
  localparam logic [11:0] SlewRst      = 12'd164;
  localparam logic [11:0] BrakeRst     = 12'd328;
  localparam logic [11:0] ZeroBandRst  = 12'd205;
  localparam logic [13:0] TrackSumRst  = 14'd2535;

  typedef struct packed {
    logic        bypass;
    logic [14:0] amplitude;
    logic [11:0] slew;
    logic [11:0] brake;
    logic [11:0] zero_band;
    logic [13:0] track_sum;
  } cfg_t;

  // Smoothed body velocity handed from the slew stage to the wheel stage.
  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
  } body_vel_t;

  function automatic logic signed [15:0] clamp_amp(input logic signed [19:0] v,
                                                   input logic [14:0] amp);
    logic signed [19:0] hi;
    logic signed [19:0] lo;
    logic signed [19:0] r;
    hi = $signed({5'b0, amp});
    lo = -hi;
    if (v > hi) begin
      r = hi;
    end else if (v < lo) begin
      r = lo;
    end else begin
      r = v;
    end
    return r[15:0];
  endfunction

endpackage

// ===== src/vsk_slew.sv =====
module vsk_slew (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  vsk_pkg::cfg_t           cfg_i,
  input  logic                    take_i,
  input  logic signed [15:0]      cmd_x_i,
  input  logic signed [15:0]      cmd_y_i,
  input  logic signed [15:0]      cmd_z_i,
  input  logic                    drain_i,
  output logic                    vel_valid_o,
  output vsk_pkg::body_vel_t      vel_o
);

  logic signed [15:0] held_x_q, held_y_q, held_z_q;
  logic signed [15:0] held_x_d, held_y_d, held_z_d;
  logic               vel_valid_q, vel_valid_d;
  vsk_pkg::body_vel_t vel_q;

  logic signed [15:0] vx, vy, vz;
  logic signed [17:0] hx, hy, hz;
  logic signed [17:0] brake_s;

  function automatic logic signed [17:0] approach(input logic signed [17:0] h,
                                                  input logic signed [15:0] t,
                                                  input logic [11:0] step);
    logic signed [17:0] te;
    logic signed [17:0] r;
    te = 18'(t);
    r  = h;
    if (te > h) begin
      r = h + $signed({6'b0, step});
      if (r > te) r = te;
    end else if (te < h) begin
      r = h - $signed({6'b0, step});
      if (r < te) r = te;
    end
    return r;
  endfunction

  function automatic logic signed [17:0] snap(input logic signed [17:0] h,
                                              input logic signed [15:0] t,
                                              input logic [11:0] band);
    logic signed [17:0] be;
    be = $signed({6'b0, band});
    if (t == 16'sd0 && h < be && h > -be) begin
      return 18'sd0;
    end
    return h;
  endfunction

  always_comb begin
    vx = vsk_pkg::clamp_amp(20'(cmd_x_i), cfg_i.amplitude);
    vy = vsk_pkg::clamp_amp(20'(cmd_y_i), cfg_i.amplitude);
    vz = vsk_pkg::clamp_amp(20'(cmd_z_i), cfg_i.amplitude);
    brake_s = $signed({6'b0, cfg_i.brake});
    hx = 18'(held_x_q);
    hy = 18'(held_y_q);
    hz = 18'(held_z_q);
    if (cfg_i.bypass) begin
      hx = 18'(vx);
      hy = 18'(vy);
      hz = 18'(vz);
    end else begin
      // Stop or reversal against the current X motion: brake X, drop Y and Z.
      if (held_x_q > 16'sd0 && vx <= 16'sd0) begin
        hx = hx - brake_s;
        if (hx < 18'sd0) hx = 18'sd0;
        hy = 18'sd0;
        hz = 18'sd0;
      end else if (held_x_q < 16'sd0 && vx >= 16'sd0) begin
        hx = hx + brake_s;
        if (hx > 18'sd0) hx = 18'sd0;
        hy = 18'sd0;
        hz = 18'sd0;
      end
      hx = snap(approach(hx, vx, cfg_i.slew), vx, cfg_i.zero_band);
      hy = snap(approach(hy, vy, cfg_i.slew), vy, cfg_i.zero_band);
      hz = snap(approach(hz, vz, cfg_i.slew), vz, cfg_i.zero_band);
    end
    held_x_d = hx[15:0];
    held_y_d = hy[15:0];
    held_z_d = hz[15:0];
  end

  assign vel_valid_d = take_i | (vel_valid_q & ~drain_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_x_q    <= '0;
      held_y_q    <= '0;
      held_z_q    <= '0;
      vel_valid_q <= 1'b0;
    end else begin
      vel_valid_q <= vel_valid_d;
      if (take_i) begin
        held_x_q <= held_x_d;
        held_y_q <= held_y_d;
        held_z_q <= held_z_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_i) begin
      vel_q.x <= held_x_d;
      vel_q.y <= held_y_d;
      vel_q.z <= held_z_d;
    end
  end

  assign vel_valid_o = vel_valid_q;
  assign vel_o       = vel_q;

`ifndef SYNTHESIS
  a_held_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_x_q != 16'sh8000 && held_y_q != 16'sh8000 && held_z_q != 16'sh8000)
    else $error("held state reached -32768");

  a_stage_matches_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take_i |=> (vel_q.x == held_x_q && vel_q.y == held_y_q && vel_q.z == held_z_q))
    else $error("stage register differs from held state");
`endif

endmodule

// ===== src/vsk_kin.sv =====
module vsk_kin (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  vsk_pkg::cfg_t           cfg_i,
  input  logic                    vel_valid_i,
  input  vsk_pkg::body_vel_t      vel_i,
  output logic                    ready_o,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic signed [15:0]      wheel_a_o,
  output logic signed [15:0]      wheel_b_o,
  output logic signed [15:0]      wheel_c_o,
  output logic signed [15:0]      wheel_d_o,
  output logic signed [15:0]      smoothed_x_o,
  output logic signed [15:0]      smoothed_y_o,
  output logic signed [15:0]      smoothed_z_o
);

  logic               out_valid_q, out_valid_d;
  logic               load;
  logic signed [30:0] prod;
  logic signed [18:0] zterm;
  logic signed [19:0] sum_m, sum_p;
  logic signed [15:0] wm_d, wp_d;
  logic signed [15:0] wm_q, wp_q;
  vsk_pkg::body_vel_t vel_q;

  assign ready_o = ~out_valid_q | ~out_stall_i;
  assign load    = ready_o & vel_valid_i;

  always_comb begin
    prod  = 31'(vel_i.z) * $signed({1'b0, cfg_i.track_sum});
    // Arithmetic shift by 12: floor of the scaled yaw term.
    zterm = prod[30:12];
    sum_m = 20'(vel_i.x) - 20'(zterm);
    sum_p = 20'(vel_i.x) + 20'(zterm);
    wm_d  = vsk_pkg::clamp_amp(sum_m, cfg_i.amplitude);
    wp_d  = vsk_pkg::clamp_amp(sum_p, cfg_i.amplitude);
  end

  assign out_valid_d = ready_o ? vel_valid_i : out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      wm_q  <= wm_d;
      wp_q  <= wp_d;
      vel_q <= vel_i;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign wheel_a_o    = wm_q;
  assign wheel_b_o    = wm_q;
  assign wheel_c_o    = wp_q;
  assign wheel_d_o    = wp_q;
  assign smoothed_x_o = vel_q.x;
  assign smoothed_y_o = vel_q.y;
  assign smoothed_z_o = vel_q.z;

`ifndef SYNTHESIS
  a_wheel_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |=> (wm_q != 16'sh8000 && wp_q != 16'sh8000))
    else $error("wheel target outside clamp range");

  a_no_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |-> !ready_o)
    else $error("result register reloaded while stalled");
`endif

endmodule

// ===== src/velocity_slew_and_wheel_kinematics.sv =====
// Velocity slew limiter with differential-drive wheel kinematics.
//
// Input channel: in_valid_i / in_stall_o carry one body velocity request
// (cmd_x_i, cmd_y_i, cmd_z_i, signed Q4.12) per control tick. Output
// channel: out_valid_o / out_stall_i carry the four wheel targets and the
// smoothed X, Y and Z velocity for that request.
// A request accepted at one clock edge is slew limited and folded into the
// held state at that edge and registered in the slew stage; the wheel
// targets are computed from that copy of the held state and loaded into the
// result register when the wheel stage is ready, which raises out_valid_o.
// One request per cycle is sustained while out_stall_i stays low.
// When out_stall_i is high the result register holds; the slew stage keeps
// accepting until it is also full, and only then raises in_stall_o.
// Reset clears the held state to zero, empties both stages and loads the
// default configuration. Configuration is written through cfg_we_i,
// cfg_addr_i and cfg_wdata_i, by the user only while no request is in flight
// (not enforced by the block); writes to unknown indexes are ignored.
module velocity_slew_and_wheel_kinematics (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [2:0]               cfg_addr_i,
  input  logic [14:0]              cfg_wdata_i,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic signed [15:0]       cmd_x_i,
  input  logic signed [15:0]       cmd_y_i,
  input  logic signed [15:0]       cmd_z_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic signed [15:0]       wheel_a_o,
  output logic signed [15:0]       wheel_b_o,
  output logic signed [15:0]       wheel_c_o,
  output logic signed [15:0]       wheel_d_o,
  output logic signed [15:0]       smoothed_x_o,
  output logic signed [15:0]       smoothed_y_o,
  output logic signed [15:0]       smoothed_z_o
);

  vsk_pkg::cfg_t      cfg_q, cfg_d;
  vsk_pkg::body_vel_t vel;
  logic               vel_valid;
  logic               kin_ready;
  logic               take;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (vsk_pkg::cfg_reg_e'(cfg_addr_i))
        vsk_pkg::REG_BYPASS:    cfg_d.bypass    = cfg_wdata_i[0];
        vsk_pkg::REG_AMPLITUDE: cfg_d.amplitude = cfg_wdata_i[14:0];
        vsk_pkg::REG_SLEW:      cfg_d.slew      = cfg_wdata_i[11:0];
        vsk_pkg::REG_BRAKE:     cfg_d.brake     = cfg_wdata_i[11:0];
        vsk_pkg::REG_ZERO_BAND: cfg_d.zero_band = cfg_wdata_i[11:0];
        vsk_pkg::REG_TRACK_SUM: cfg_d.track_sum = cfg_wdata_i[13:0];
        default:                cfg_d           = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.bypass    <= vsk_pkg::BypassRst;
      cfg_q.amplitude <= vsk_pkg::AmplitudeRst;
      cfg_q.slew      <= vsk_pkg::SlewRst;
      cfg_q.brake     <= vsk_pkg::BrakeRst;
      cfg_q.zero_band <= vsk_pkg::ZeroBandRst;
      cfg_q.track_sum <= vsk_pkg::TrackSumRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // The slew stage is free when empty or when the wheel stage drains it.
  assign in_stall_o = vel_valid & ~kin_ready;
  assign take       = in_valid_i & ~in_stall_o;

  vsk_slew u_slew (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .take_i      (take),
    .cmd_x_i     (cmd_x_i),
    .cmd_y_i     (cmd_y_i),
    .cmd_z_i     (cmd_z_i),
    .drain_i     (kin_ready),
    .vel_valid_o (vel_valid),
    .vel_o       (vel)
  );

  vsk_kin u_kin (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .vel_valid_i  (vel_valid),
    .vel_i        (vel),
    .ready_o      (kin_ready),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .wheel_a_o    (wheel_a_o),
    .wheel_b_o    (wheel_b_o),
    .wheel_c_o    (wheel_c_o),
    .wheel_d_o    (wheel_d_o),
    .smoothed_x_o (smoothed_x_o),
    .smoothed_y_o (smoothed_y_o),
    .smoothed_z_o (smoothed_z_o)
  );

`ifndef SYNTHESIS
  a_take_frees_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && vel_valid) |-> kin_ready)
    else $error("request accepted over an undrained slew stage");
`endif

endmodule

// ===== bench/testbench.sv =====
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CycleLimit = 300000;
  localparam logic [2:0] UnusedRegIdx = 3'd6;

  typedef struct {
    logic signed [15:0] wheel_a;
    logic signed [15:0] wheel_b;
    logic signed [15:0] wheel_c;
    logic signed [15:0] wheel_d;
    logic signed [15:0] smoothed_x;
    logic signed [15:0] smoothed_y;
    logic signed [15:0] smoothed_z;
  } wheel_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [2:0] cfg_addr_i = '0;
  logic [14:0] cfg_wdata_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic signed [15:0] cmd_x_i = '0;
  logic signed [15:0] cmd_y_i = '0;
  logic signed [15:0] cmd_z_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic signed [15:0] wheel_a_o;
  logic signed [15:0] wheel_b_o;
  logic signed [15:0] wheel_c_o;
  logic signed [15:0] wheel_d_o;
  logic signed [15:0] smoothed_x_o;
  logic signed [15:0] smoothed_y_o;
  logic signed [15:0] smoothed_z_o;

  // Shadow of the block's configuration and held body velocity.
  logic model_bypass;
  int model_amp;
  int model_slew;
  int model_brake;
  int model_zero_band;
  int model_track;
  int held_x;
  int held_y;
  int held_z;

  wheel_result_t pending_wheel_targets[$];
  int error_count = 0;
  int cycle_count = 0;
  int burst_left = 0;
  int gap_max = 0;
  int stall_pct = 0;
  int stall_left = 0;

  velocity_slew_and_wheel_kinematics uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_addr_i   (cfg_addr_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .cmd_x_i      (cmd_x_i),
    .cmd_y_i      (cmd_y_i),
    .cmd_z_i      (cmd_z_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .wheel_a_o    (wheel_a_o),
    .wheel_b_o    (wheel_b_o),
    .wheel_c_o    (wheel_c_o),
    .wheel_d_o    (wheel_d_o),
    .smoothed_x_o (smoothed_x_o),
    .smoothed_y_o (smoothed_y_o),
    .smoothed_z_o (smoothed_z_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic int clamp_mag(input int v);
    if (v > model_amp) return model_amp;
    if (v < -model_amp) return -model_amp;
    return v;
  endfunction

  function automatic int step_toward(input int h, input int target);
    if (target > h) begin
      h = h + model_slew;
      if (h > target) h = target;
    end else if (target < h) begin
      h = h - model_slew;
      if (h < target) h = target;
    end
    return h;
  endfunction

  function automatic int snap_small(input int h, input int target);
    if (target == 0 && h < model_zero_band && h > -model_zero_band) return 0;
    return h;
  endfunction

  function automatic wheel_result_t advance_kinematics(input logic signed [15:0] cx,
                                                       input logic signed [15:0] cy,
                                                       input logic signed [15:0] cz);
    int vx;
    int vy;
    int vz;
    int zterm;
    int w_minus;
    int w_plus;
    wheel_result_t r;
    vx = clamp_mag(int'(cx));
    vy = clamp_mag(int'(cy));
    vz = clamp_mag(int'(cz));
    if (model_bypass) begin
      held_x = vx;
      held_y = vy;
      held_z = vz;
    end else begin
      // A stop or reversal against the current X motion brakes X and drops Y and Z.
      if (held_x > 0 && vx <= 0) begin
        held_x = held_x - model_brake;
        if (held_x < 0) held_x = 0;
        held_y = 0;
        held_z = 0;
      end
      if (held_x < 0 && vx >= 0) begin
        held_x = held_x + model_brake;
        if (held_x > 0) held_x = 0;
        held_y = 0;
        held_z = 0;
      end
      held_x = snap_small(step_toward(held_x, vx), vx);
      held_y = snap_small(step_toward(held_y, vy), vy);
      held_z = snap_small(step_toward(held_z, vz), vz);
    end
    // The product fits in 32 bits; the arithmetic shift rounds toward minus infinity.
    zterm = (held_z * model_track) >>> 12;
    w_minus = clamp_mag(held_x - zterm);
    w_plus = clamp_mag(held_x + zterm);
    r.wheel_a = w_minus[15:0];
    r.wheel_b = w_minus[15:0];
    r.wheel_c = w_plus[15:0];
    r.wheel_d = w_plus[15:0];
    r.smoothed_x = held_x[15:0];
    r.smoothed_y = held_y[15:0];
    r.smoothed_z = held_z[15:0];
    return r;
  endfunction

  function automatic logic signed [15:0] pick_command();
    int v;
    case ($urandom_range(0, 7))
      0: v = 32767;
      1: v = -32768;
      2: v = 0;
      3: v = model_amp;
      4: v = -model_amp;
      5: v = int'($urandom_range(0, 400)) - 200;
      default: v = int'($urandom());
    endcase
    return v[15:0];
  endfunction

  task automatic compare_field(input string name, input logic signed [15:0] exp_v,
                               input logic signed [15:0] act_v);
    if (act_v !== exp_v) begin
      $display("%0t: %s expected %0d, got %0d", $time, name, exp_v, act_v);
      error_count++;
    end
  endtask

  always @(posedge clk_i) begin
    wheel_result_t exp_r;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_wheel_targets.size() == 0) begin
        $display("%0t: result with no request pending, expected none, got wheel_a %0d",
                 $time, wheel_a_o);
        error_count++;
      end else begin
        exp_r = pending_wheel_targets.pop_front();
        compare_field("wheel_a", exp_r.wheel_a, wheel_a_o);
        compare_field("wheel_b", exp_r.wheel_b, wheel_b_o);
        compare_field("wheel_c", exp_r.wheel_c, wheel_c_o);
        compare_field("wheel_d", exp_r.wheel_d, wheel_d_o);
        compare_field("smoothed_x", exp_r.smoothed_x, smoothed_x_o);
        compare_field("smoothed_y", exp_r.smoothed_y, smoothed_y_o);
        compare_field("smoothed_z", exp_r.smoothed_z, smoothed_z_o);
      end
    end
  end

  // The receiver stalls in runs of random length, the share set per test.
  always @(posedge clk_i) begin
    if (stall_left == 0) begin
      stall_left = $urandom_range(1, 8);
      out_stall_i <= (stall_pct > 0) && ($urandom_range(0, 99) < stall_pct);
    end
    stall_left--;
  end

  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Some tests failed");
    $finish;
  end

  task automatic send_command(input logic signed [15:0] cx, input logic signed [15:0] cy,
                              input logic signed [15:0] cz);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if (gap_max > 0) begin
        in_valid_i <= 1'b0;
        repeat ($urandom_range(1, gap_max)) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i <= 1'b1;
    cmd_x_i <= cx;
    cmd_y_i <= cy;
    cmd_z_i <= cz;
    do @(posedge clk_i); while (in_stall_o);
    pending_wheel_targets.push_back(advance_kinematics(cx, cy, cz));
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    burst_left = 0;
    while (pending_wheel_targets.size() > 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_register(input logic [2:0] idx, input logic [14:0] value);
    cfg_we_i <= 1'b1;
    cfg_addr_i <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    case (idx)
      vsk_pkg::REG_BYPASS:    model_bypass = value[0];
      vsk_pkg::REG_AMPLITUDE: model_amp = value;
      vsk_pkg::REG_SLEW:      model_slew = value[11:0];
      vsk_pkg::REG_BRAKE:     model_brake = value[11:0];
      vsk_pkg::REG_ZERO_BAND: model_zero_band = value[11:0];
      vsk_pkg::REG_TRACK_SUM: model_track = value[13:0];
      default: ;
    endcase
  endtask

  task automatic test_reset();
    model_bypass = vsk_pkg::BypassRst;
    model_amp = vsk_pkg::AmplitudeRst;
    model_slew = vsk_pkg::SlewRst;
    model_brake = vsk_pkg::BrakeRst;
    model_zero_band = vsk_pkg::ZeroBandRst;
    model_track = vsk_pkg::TrackSumRst;
    held_x = 0;
    held_y = 0;
    held_z = 0;
    rst_ni <= 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
  endtask

  task automatic test_directed();
    gap_max = 3;
    stall_pct = 30;
    // Default configuration: field extremes, a stop and reversals in both directions.
    send_command(16'sh7FFF, 16'sh8000, 16'sh0000);
    send_command(16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
    send_command(16'sh7FFF, 16'sh7FFF, 16'sh8000);
    send_command(16'sh0000, 16'sh0000, 16'sh0000);
    send_command(16'sh8000, 16'sh0001, -16'sh0001);
    send_command(-16'sh0001, -16'sh0001, 16'sh0001);
    send_command(16'sh0001, 16'sh0000, 16'sh0000);
    send_command(16'sh0000, 16'sh0000, 16'sh0000);
    drain_results();
    // Bypass at full amplitude, so the wheel targets saturate.
    write_register(vsk_pkg::REG_BYPASS, 15'h7FFF);
    write_register(vsk_pkg::REG_AMPLITUDE, 15'h7FFF);
    send_command(16'sh7FFF, 16'sh8000, 16'sh7FFF);
    send_command(16'sh8000, 16'sh0000, 16'sh0000);
    send_command(16'sh7FFF, 16'sh0064, 16'sh0FA0);
    drain_results();
    // Amplitude lowered under the held values: only the wheels are clamped.
    write_register(vsk_pkg::REG_BYPASS, 15'h0000);
    write_register(vsk_pkg::REG_AMPLITUDE, 15'd1000);
    send_command(16'sh7FFF, 16'sh0000, 16'sh0000);
    drain_results();
    // Unknown index is ignored, over-wide data is masked, no snapping with a zero band of 0.
    write_register(UnusedRegIdx, 15'h0000);
    write_register(vsk_pkg::REG_SLEW, 15'h7FFF);
    write_register(vsk_pkg::REG_BRAKE, 15'h7FFF);
    write_register(vsk_pkg::REG_ZERO_BAND, 15'h0000);
    send_command(16'sh0000, 16'sh0000, 16'sh0000);
    send_command(16'sh0000, 16'sh0000, 16'sh0000);
    drain_results();
    write_register(vsk_pkg::REG_AMPLITUDE, 15'h0000);
    write_register(vsk_pkg::REG_TRACK_SUM, 15'h7FFF);
    send_command(16'sh7FFF, 16'sh8000, 16'sh3039);
    send_command(16'sh8000, 16'sh7FFF, -16'sh0001);
    drain_results();
  endtask

  task automatic test_random_phase(input logic [14:0] byp, input logic [14:0] amp,
                                   input logic [14:0] slew, input logic [14:0] brake,
                                   input logic [14:0] zband, input logic [14:0] track,
                                   input int gaps, input int stalls, input int items);
    int sent;
    int hold;
    int k;
    logic signed [15:0] tx;
    logic signed [15:0] ty;
    logic signed [15:0] tz;
    sent = 0;
    write_register(vsk_pkg::REG_BYPASS, byp);
    write_register(vsk_pkg::REG_AMPLITUDE, amp);
    write_register(vsk_pkg::REG_SLEW, slew);
    write_register(vsk_pkg::REG_BRAKE, brake);
    write_register(vsk_pkg::REG_ZERO_BAND, zband);
    write_register(vsk_pkg::REG_TRACK_SUM, track);
    gap_max = gaps;
    stall_pct = stalls;
    while (sent < items) begin
      if ($urandom_range(0, 4) == 0) begin
        send_command(pick_command(), pick_command(), pick_command());
        sent++;
      end else begin
        // Hold one command for a run of random length, with some Y and Z jitter.
        tx = pick_command();
        ty = pick_command();
        tz = pick_command();
        hold = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 160) : $urandom_range(1, 30);
        for (k = 0; k < hold && sent < items; k++) begin
          if ($urandom_range(0, 5) == 0) ty = pick_command();
          if ($urandom_range(0, 5) == 0) tz = pick_command();
          send_command(tx, ty, tz);
          sent++;
        end
      end
    end
    drain_results();
  endtask

  initial begin
    test_reset();
    test_directed();
    test_random_phase(15'd0, 15'd14336, 15'd164, 15'd328, 15'd205, 15'd2535, 4, 30, 250);
    test_random_phase(15'd0, 15'd32767, 15'd4095, 15'd4095, 15'd4095, 15'd16383, 0, 0, 250);
    test_random_phase(15'd1, 15'd20000, 15'd100, 15'd200, 15'd300, 15'd8000, 6, 50, 250);
    test_random_phase(15'd0, 15'd0, 15'd50, 15'd60, 15'd0, 15'd0, 2, 70, 250);
    test_random_phase(15'd0, 15'd4000, 15'd0, 15'd0, 15'd0, 15'd12000, 3, 20, 250);
    test_random_phase(15'd0, 15'd30000, 15'd1000, 15'd1, 15'd1000, 15'd16383, 5, 40, 250);
    test_random_phase(15'($urandom()), 15'($urandom()), 15'($urandom()), 15'($urandom()),
                      15'($urandom()), 15'($urandom()), 3, 35, 250);
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
